FILE: src/aesd_pkg.sv
// Shared types, constants and byte tables for the AES-256 decryption unit.
`default_nettype none

package aesd_pkg;

  // Register indexes on the configuration port.
  localparam logic [2:0] CFG_KEY0 = 3'd0;
  localparam logic [2:0] CFG_KEY1 = 3'd1;
  localparam logic [2:0] CFG_KEY2 = 3'd2;
  localparam logic [2:0] CFG_KEY3 = 3'd3;
  localparam logic [2:0] CFG_IV_HIGH = 3'd4;
  localparam logic [2:0] CFG_IV_LOW = 3'd5;
  localparam logic [2:0] CFG_MODE = 3'd6;

  // Fifteen round keys, numbered 0 to 14.
  localparam logic [3:0] ROUND_LAST = 4'd14;
  localparam logic [3:0] ROUND_FIRST_INV = 4'd13;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
    logic        first_block;
    logic        last_block;
  } aesd_in_t;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
    logic        end_of_buffer;
  } aesd_out_t;

  // One round key write from the key schedule into the key store.
  typedef struct packed {
    logic         en;
    logic [3:0]   addr;
    logic [127:0] data;
  } aesd_kwr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_FETCH,
    ST_INIT,
    ST_ROUND,
    ST_WRITE
  } aesd_state_t;

  localparam logic [0:255][7:0] SBOX = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
  };

  localparam logic [0:255][7:0] SBOX_REV = {
    128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
    128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
    128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
    128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
    128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
    128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
    128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
    128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d
  };

  // Multiply by x in GF(2^8) with the AES reduction polynomial.
  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
  endfunction

endpackage

`default_nettype wire

FILE: src/aes256_block_decrypt_ecb_cbc_unit.sv
// Top level of the AES-256 ECB/CBC block decryption unit with its sequencer.
`default_nettype none

// Usage
// The input channel (in_valid, in_ready, in_data) takes one 128-bit ciphertext
// block per beat, with its first-block and last-block flags. The output channel
// (out_valid, out_ready, out_data) returns one plaintext block per input beat,
// in order, with the last-block flag copied to end_of_buffer.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
// the four key words, the two IV words and the chaining mode; it is always ready
// and should only be used while the unit is idle. Unknown indexes are ignored.
// Any key write forces the key schedule to be rebuilt before the next block:
// key expansion writes all fifteen round keys, then the last round key is fetched.
// With round keys in place, a block passes through the initial key add, the
// fourteen rounds in the single shared inverse round unit (one round per cycle)
// and the output write. The unit takes one block at a time; in_ready is low
// while a block is in work. If the receiver stalls, a finished block waits in
// the write state until the output register frees up. Reset clears the state,
// the configuration registers, the chaining value and the round-key status,
// so the first block after reset always expands the key.

module aes256_block_decrypt_ecb_cbc_unit
  import aesd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire aesd_in_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output aesd_out_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  aesd_state_t  state, state_next;

  // Configuration registers.
  logic [63:0]  key_part [4];
  logic [127:0] iv;
  logic         mode;

  // Sequencer and datapath registers.
  logic         keys_ready;
  logic [127:0] chain;
  logic [127:0] cipher_q;
  logic         first_q;
  logic         last_q;
  logic [127:0] blk;
  logic [3:0]   rnd;

  // Round key store and its registered read port.
  logic [127:0] rk_mem [15];
  logic [127:0] key_q;
  logic [3:0]   rd_addr;

  logic         in_fire;
  logic         cfg_fire;
  logic         out_free;
  logic         ks_start;
  logic         expand_done;
  logic [127:0] round_res;
  logic [127:0] chain_sel;
  aesd_kwr_t    kwr;

  assign in_fire     = in_valid && in_ready;
  assign cfg_fire    = cfg_valid && cfg_ready;
  assign out_free    = !out_valid || out_ready;
  assign expand_done = kwr.en && (kwr.addr == ROUND_LAST);

  aesd_key_sched u_key_sched (
    .clk   (clk),
    .rst   (rst),
    .start (ks_start),
    .key   ({key_part[0], key_part[1], key_part[2], key_part[3]}),
    .kwr   (kwr)
  );

  aesd_inv_round u_inv_round (
    .blk  (blk),
    .rkey (key_q),
    .mix  (rnd != 4'd0),
    .res  (round_res)
  );

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = keys_ready ? ST_INIT : ST_EXPAND;
        end
      end
      ST_EXPAND: begin
        if (expand_done) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: state_next = ST_INIT;
      ST_INIT:  state_next = ST_ROUND;
      ST_ROUND: begin
        if (rnd == 4'd0) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs. While idle the store is read at the last round key so
  // that it is already waiting when a block arrives.
  always_comb begin
    in_ready = 1'b0;
    ks_start = 1'b0;
    rd_addr  = ROUND_LAST;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        ks_start = in_valid && !keys_ready;
      end
      ST_INIT:  rd_addr = ROUND_FIRST_INV;
      ST_ROUND: rd_addr = (rnd == 4'd0) ? ROUND_LAST : rnd - 4'd1;
      default:  rd_addr = ROUND_LAST;
    endcase
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes; a key write invalidates the stored round keys.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        key_part[i] <= 64'd0;
      end
      iv         <= 128'd0;
      mode       <= 1'b0;
      keys_ready <= 1'b0;
    end else begin
      if (expand_done) begin
        keys_ready <= 1'b1;
      end
      if (cfg_fire) begin
        case (cfg_index)
          CFG_KEY0, CFG_KEY1, CFG_KEY2, CFG_KEY3: begin
            key_part[cfg_index[1:0]] <= cfg_data;
            keys_ready               <= 1'b0;
          end
          CFG_IV_HIGH: iv[127:64] <= cfg_data;
          CFG_IV_LOW:  iv[63:0]   <= cfg_data;
          CFG_MODE:    mode       <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (kwr.en) begin
      rk_mem[kwr.addr] <= kwr.data;
    end
    key_q <= rk_mem[rd_addr];
  end

  // Capture the block, run the rounds, then hand over to the output register.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cipher_q <= {in_data.cipher_high, in_data.cipher_low};
      first_q  <= in_data.first_block;
      last_q   <= in_data.last_block;
    end
    if (state == ST_INIT) begin
      blk <= cipher_q ^ key_q;
    end else if (state == ST_ROUND) begin
      blk <= round_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rnd <= 4'd0;
    end else if (state == ST_INIT) begin
      rnd <= ROUND_FIRST_INV;
    end else if (state == ST_ROUND && rnd != 4'd0) begin
      rnd <= rnd - 4'd1;
    end
  end

  // In ECB mode nothing is mixed in; the chaining value still follows the
  // ciphertext so that a later switch to CBC chains from the latest block.
  assign chain_sel = mode ? (first_q ? iv : chain) : 128'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      chain     <= 128'd0;
    end else if (state == ST_WRITE && out_free) begin
      out_valid <= 1'b1;
      chain     <= cipher_q;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_WRITE && out_free) begin
      out_data.plain_high    <= blk[127:64] ^ chain_sel[127:64];
      out_data.plain_low     <= blk[63:0] ^ chain_sel[63:0];
      out_data.end_of_buffer <= last_q;
    end
  end

`ifndef SYNTHESIS
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("input taken again straight after a beat");

  a_kwr_in_expand: assert property (@(posedge clk) disable iff (rst)
    kwr.en |-> (state == ST_EXPAND))
    else $error("key store written outside key expansion");

  a_round_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && rnd != 4'd0) |=> (rnd == $past(rnd) - 4'd1))
    else $error("round counter did not step down");

  a_out_from_write: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_WRITE))
    else $error("result shown without a finished block");

  a_rounds_need_keys: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INIT) |-> keys_ready)
    else $error("rounds started before the key schedule was built");
`endif

endmodule

`default_nettype wire

FILE: src/aesd_key_sched.sv
// AES-256 key schedule that produces one 128-bit round key per cycle.
`default_nettype none

module aesd_key_sched
  import aesd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [255:0] key,
  output aesd_kwr_t         kwr
);

  logic         busy;
  logic [3:0]   cnt;
  logic [7:0]   rcon;
  logic [127:0] prev2;
  logic [127:0] prev1;

  logic [31:0]  last_word;
  logic [31:0]  rot_word;
  logic [31:0]  sub_word;
  logic [31:0]  temp;
  logic [31:0]  w0, w1, w2, w3;
  logic [127:0] gen;

  always_comb begin
    last_word = prev1[31:0];
    rot_word  = cnt[0] ? last_word : {last_word[23:0], last_word[31:24]};
    for (int i = 0; i < 4; i++) begin
      sub_word[8*i +: 8] = SBOX[rot_word[8*i +: 8]];
    end
    // Even-numbered keys from key 2 on take the rotated word and the round constant.
    temp = cnt[0] ? sub_word : (sub_word ^ {rcon, 24'h000000});
    w0   = prev2[127:96] ^ temp;
    w1   = prev2[95:64] ^ w0;
    w2   = prev2[63:32] ^ w1;
    w3   = prev2[31:0] ^ w2;
    case (cnt)
      4'd0:    gen = key[255:128];
      4'd1:    gen = key[127:0];
      default: gen = {w0, w1, w2, w3};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 4'd0;
      rcon <= 8'h01;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 4'd0;
      rcon <= 8'h01;
    end else if (busy) begin
      cnt <= cnt + 4'd1;
      if (cnt == ROUND_LAST) begin
        busy <= 1'b0;
      end
      if (!cnt[0] && cnt != 4'd0) begin
        rcon <= xtime(rcon);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      prev2 <= prev1;
      prev1 <= gen;
    end
  end

  assign kwr.en   = busy;
  assign kwr.addr = cnt;
  assign kwr.data = gen;

endmodule

`default_nettype wire

FILE: src/aesd_inv_round.sv
// One AES inverse round: inverse shift, inverse substitution, key add, and inverse mix when mix is set.
`default_nettype none

module aesd_inv_round
  import aesd_pkg::*;
(
  input  wire logic [127:0] blk,
  input  wire logic [127:0] rkey,
  input  wire logic         mix,
  output logic [127:0]      res
);

  logic [7:0] st [16];
  logic [7:0] sb [16];
  logic [7:0] mx [16];
  logic [7:0] a0, a1, a2, a3;

  function automatic logic [7:0] mul9(input logic [7:0] x);
    logic [7:0] m2, m4, m8;
    m2 = xtime(x);
    m4 = xtime(m2);
    m8 = xtime(m4);
    mul9 = m8 ^ x;
  endfunction

  function automatic logic [7:0] mulb(input logic [7:0] x);
    logic [7:0] m2, m4, m8;
    m2 = xtime(x);
    m4 = xtime(m2);
    m8 = xtime(m4);
    mulb = m8 ^ m2 ^ x;
  endfunction

  function automatic logic [7:0] muld(input logic [7:0] x);
    logic [7:0] m2, m4, m8;
    m2 = xtime(x);
    m4 = xtime(m2);
    m8 = xtime(m4);
    muld = m8 ^ m4 ^ x;
  endfunction

  function automatic logic [7:0] mule(input logic [7:0] x);
    logic [7:0] m2, m4, m8;
    m2 = xtime(x);
    m4 = xtime(m2);
    m8 = xtime(m4);
    mule = m8 ^ m4 ^ m2;
  endfunction

  always_comb begin
    a0 = 8'h00;
    a1 = 8'h00;
    a2 = 8'h00;
    a3 = 8'h00;
    for (int i = 0; i < 16; i++) begin
      st[i] = blk[127 - 8*i -: 8];
    end
    // Byte at row r, column c comes from column c - r.
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sb[4*c + r] = SBOX_REV[st[4*((c - r + 4) % 4) + r]] ^ rkey[127 - 8*(4*c + r) -: 8];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = sb[4*c];
      a1 = sb[4*c + 1];
      a2 = sb[4*c + 2];
      a3 = sb[4*c + 3];
      mx[4*c]     = mule(a0) ^ mulb(a1) ^ muld(a2) ^ mul9(a3);
      mx[4*c + 1] = mul9(a0) ^ mule(a1) ^ mulb(a2) ^ muld(a3);
      mx[4*c + 2] = muld(a0) ^ mul9(a1) ^ mule(a2) ^ mulb(a3);
      mx[4*c + 3] = mulb(a0) ^ muld(a1) ^ mul9(a2) ^ mule(a3);
    end
    for (int i = 0; i < 16; i++) begin
      res[127 - 8*i -: 8] = mix ? mx[i] : sb[i];
    end
  end

endmodule

`default_nettype wire
